// ===== hdl/crop_rotate_pixel_address_gen_core_defines.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CROP_ROTATE_PIXEL_ADDRESS_GEN_CORE_DEFINES_SVH
`define CROP_ROTATE_PIXEL_ADDRESS_GEN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRPAG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRPAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crpag_pkg.sv =====
`default_nettype none

package crpag_pkg;

  localparam int unsigned MAX_DIMENSION    = 4096;
  localparam int unsigned LINE_ALIGN_BYTES = 4;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned LINE_W     = 15;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SETTLE_W   = 3;

  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUARTER_TURNS   = 3'd0,
    REG_BYTES_PER_PIXEL = 3'd1,
    REG_SOURCE_WIDTH    = 3'd2,
    REG_CROP_LEFT       = 3'd3,
    REG_CROP_WIDTH      = 3'd4,
    REG_WINDOW_HEIGHT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [ADDR_W-1:0] xstep;
    logic [ADDR_W-1:0] ystep;
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  wm1;
    logic [CNT_W-1:0]  hm1;
    logic              err;
    logic              busy;
    logic              load;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  pixel_out;
    logic              last_pixel;
    logic              config_error;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/crpag_pix_if.sv =====
`default_nettype none

interface crpag_pix_if import crpag_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/crpag_res_if.sv =====
`default_nettype none

interface crpag_res_if import crpag_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [PIX_W-1:0]  pixel_out;
  logic              last_pixel;
  logic              config_error;

  modport source (output valid, output dest_address, output pixel_out,
                  output last_pixel, output config_error, input ready);
  modport sink (input valid, input dest_address, input pixel_out,
                input last_pixel, input config_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/crpag_cfg.sv =====
`default_nettype none

module crpag_cfg import crpag_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  rot_e              qt_q;
  logic [BPP_W-1:0]  bpp_q;
  logic [DIM_W-1:0]  sw_q;
  logic [CNT_W-1:0]  cl_q;
  logic [DIM_W-1:0]  cw_q;
  logic [DIM_W-1:0]  wh_q;
  logic              wr_valid;
  logic [SETTLE_W-1:0] settle_d, settle_q;

  logic [DIM_W-1:0] eff_sw, room, cw_c, w_c, h_c;
  logic [BPP_W-1:0] b_c;
  logic             err_c;

  rot_e             a_qt_q;
  logic [BPP_W-1:0] a_b_q;
  logic [DIM_W-1:0] a_w_q, a_h_q;
  logic             a_err_q;

  logic [DIM_W-1:0]  sel_dim;
  logic [15:0]       line_raw;
  logic [15:0]       line_pad;

  rot_e              b_qt_q;
  logic [BPP_W-1:0]  b_b_q;
  logic [CNT_W-1:0]  b_wm1_q, b_hm1_q;
  logic [LINE_W-1:0] b_line_q;
  logic              b_err_q;

  logic [CNT_W-1:0]  mul_a, small_a;
  logic [26:0]       prod;
  logic [14:0]       pix_prod;
  logic [ADDR_W-1:0] line_ext, b_ext, start_c, xstep_c, ystep_c;

  logic [ADDR_W-1:0] c_xstep_q, c_ystep_q, c_start_q;
  logic [CNT_W-1:0]  c_wm1_q, c_hm1_q;
  logic              c_err_q;

  assign wr_valid = cfg_we_i && (cfg_idx_i <= REG_WINDOW_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qt_q  <= ROT_0;
      bpp_q <= 3'd4;
      sw_q  <= 13'd1;
      cl_q  <= 12'd0;
      cw_q  <= 13'd1;
      wh_q  <= 13'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_QUARTER_TURNS:   qt_q  <= rot_e'(cfg_wdata_i[1:0]);
        REG_BYTES_PER_PIXEL: bpp_q <= cfg_wdata_i[BPP_W-1:0];
        REG_SOURCE_WIDTH:    sw_q  <= cfg_wdata_i;
        REG_CROP_LEFT:       cl_q  <= cfg_wdata_i[CNT_W-1:0];
        REG_CROP_WIDTH:      cw_q  <= cfg_wdata_i;
        REG_WINDOW_HEIGHT:   wh_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_d = settle_q;
    if (wr_valid) begin
      settle_d = SETTLE_CYCLES;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_CYCLES;
    end else begin
      settle_q <= settle_d;
    end
  end

  // First stage: effective sizes after clamping.
  always_comb begin
    eff_sw = (sw_q > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : sw_q;
    err_c  = {1'b0, cl_q} >= eff_sw;
    room   = err_c ? DIM_W'(1) : (eff_sw - {1'b0, cl_q});
    if (cw_q == '0) begin
      cw_c = DIM_W'(1);
    end else if (cw_q > DIM_W'(MAX_DIMENSION)) begin
      cw_c = DIM_W'(MAX_DIMENSION);
    end else begin
      cw_c = cw_q;
    end
    w_c = (cw_c > room) ? room : cw_c;
    if (wh_q == '0) begin
      h_c = DIM_W'(1);
    end else if (wh_q > DIM_W'(MAX_DIMENSION)) begin
      h_c = DIM_W'(MAX_DIMENSION);
    end else begin
      h_c = wh_q;
    end
    if (bpp_q == '0) begin
      b_c = 3'd1;
    end else if (bpp_q > 3'd4) begin
      b_c = 3'd4;
    end else begin
      b_c = bpp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_qt_q  <= qt_q;
    a_b_q   <= b_c;
    a_w_q   <= w_c;
    a_h_q   <= h_c;
    a_err_q <= err_c;
  end

  // Second stage: padded destination line length.
  always_comb begin
    sel_dim  = a_qt_q[0] ? a_h_q : a_w_q;
    line_raw = 16'(sel_dim) * 16'(a_b_q);
    line_pad = (line_raw + 16'(LINE_ALIGN_BYTES - 1)) & ~16'(LINE_ALIGN_BYTES - 1);
  end

  always_ff @(posedge clk_i) begin
    b_qt_q   <= a_qt_q;
    b_b_q    <= a_b_q;
    b_wm1_q  <= CNT_W'(a_w_q - 1'b1);
    b_hm1_q  <= CNT_W'(a_h_q - 1'b1);
    b_line_q <= line_pad[LINE_W-1:0];
    b_err_q  <= a_err_q;
  end

  // Third stage: start address and the two address steps.
  always_comb begin
    mul_a    = (b_qt_q == ROT_90) ? b_wm1_q : b_hm1_q;
    small_a  = (b_qt_q == ROT_180) ? b_wm1_q : b_hm1_q;
    prod     = 27'(mul_a) * 27'(b_line_q);
    pix_prod = 15'(small_a) * 15'(b_b_q);
    line_ext = ADDR_W'(b_line_q);
    b_ext    = ADDR_W'(b_b_q);
    case (b_qt_q)
      ROT_90: begin
        start_c = prod[ADDR_W-1:0];
        xstep_c = ADDR_W'(0) - line_ext;
        ystep_c = b_ext;
      end
      ROT_180: begin
        start_c = prod[ADDR_W-1:0] + ADDR_W'(pix_prod);
        xstep_c = ADDR_W'(0) - b_ext;
        ystep_c = ADDR_W'(0) - line_ext;
      end
      ROT_270: begin
        start_c = ADDR_W'(pix_prod);
        xstep_c = line_ext;
        ystep_c = ADDR_W'(0) - b_ext;
      end
      default: begin
        start_c = '0;
        xstep_c = b_ext;
        ystep_c = line_ext;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_xstep_q <= xstep_c;
    c_ystep_q <= ystep_c;
    c_start_q <= start_c;
    c_wm1_q   <= b_wm1_q;
    c_hm1_q   <= b_hm1_q;
    c_err_q   <= b_err_q;
  end

  assign cfg_o.xstep = c_xstep_q;
  assign cfg_o.ystep = c_ystep_q;
  assign cfg_o.start = c_start_q;
  assign cfg_o.wm1   = c_wm1_q;
  assign cfg_o.hm1   = c_hm1_q;
  assign cfg_o.err   = c_err_q;
  assign cfg_o.busy  = settle_q != '0;
  assign cfg_o.load  = settle_q == SETTLE_W'(1);

endmodule

`default_nettype wire

// ===== hdl/crpag_addr.sv =====
`default_nettype none

module crpag_addr import crpag_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic             fire_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  output res_t                  res_o
);

  logic [CNT_W-1:0]  row_d, row_q, col_d, col_q;
  logic [ADDR_W-1:0] rsa_d, rsa_q, cur_d, cur_q;
  logic              row_end, col_end;

  assign row_end = row_q == cfg_i.hm1;
  assign col_end = col_q == cfg_i.wm1;

  always_comb begin
    res_o.pixel_out    = pixel_i;
    res_o.config_error = cfg_i.err;
    res_o.dest_address = cfg_i.err ? '0 : cur_q;
    res_o.last_pixel   = !cfg_i.err && row_end && col_end;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    rsa_d = rsa_q;
    cur_d = cur_q;
    if (cfg_i.load) begin
      row_d = '0;
      col_d = '0;
      rsa_d = cfg_i.start;
      cur_d = cfg_i.start;
    end else if (fire_i && !cfg_i.err) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          row_d = '0;
          rsa_d = cfg_i.start;
          cur_d = cfg_i.start;
        end else begin
          row_d = row_q + 1'b1;
          rsa_d = rsa_q + cfg_i.ystep;
          cur_d = rsa_q + cfg_i.ystep;
        end
      end else begin
        col_d = col_q + 1'b1;
        cur_d = cur_q + cfg_i.xstep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      rsa_q <= '0;
      cur_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      rsa_q <= rsa_d;
      cur_q <= cur_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crpag_out_buf.sv =====
`default_nettype none

module crpag_out_buf import crpag_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      data_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output res_t      data_o
);

  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crop_rotate_pixel_address_gen_core.sv =====
// Pixel address generator for cropped and rotated bitmaps.
// Pixels of the window arrive on pix_i in row-major order, one per
// transaction. For each one, res_o carries the byte address in the rotated
// destination buffer, the pixel value unchanged, a flag on the last pixel of
// the window and a flag when the crop start lies outside the source.
// Each result is registered in the output buffer before it shows on res_o,
// and one pixel can be taken every cycle while pix_i.ready is high.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write them only while the block is idle, which it does not enforce.
// Every write to a valid index restarts the window and holds pix_i.ready low
// while sizes, line length, start address and steps are worked out in a
// three-stage pipeline. After reset the registers take their default values
// and the same settling applies before the first pixel is taken. A two-entry
// output buffer keeps pix_i.ready high while one result waits; when the
// receiver stalls for longer, pix_i.ready falls until it drains.
`default_nettype none

module crop_rotate_pixel_address_gen_core import crpag_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  crpag_pix_if.sink                  pix_i,
  crpag_res_if.source                res_o
);

  cfg_t cfg;
  res_t res_d, res_q;
  logic buf_ready, fire;

  assign pix_i.ready = buf_ready && !cfg.busy;
  assign fire        = pix_i.valid && pix_i.ready;

  crpag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  crpag_addr u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (fire),
    .pixel_i (pix_i.pixel_value),
    .res_o   (res_d)
  );

  crpag_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res_d),
    .ready_o (buf_ready),
    .valid_o (res_o.valid),
    .pop_i   (res_o.ready),
    .data_o  (res_q)
  );

  assign res_o.dest_address = res_q.dest_address;
  assign res_o.pixel_out    = res_q.pixel_out;
  assign res_o.last_pixel   = res_q.last_pixel;
  assign res_o.config_error = res_q.config_error;

endmodule

`default_nettype wire

// ===== hdl/crpag_checker.sv =====
`default_nettype none
`include "crop_rotate_pixel_address_gen_core_defines.svh"

module crpag_checker import crpag_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic                 pix_ready_i,
  input wire logic                 res_valid_i,
  input wire logic                 res_ready_i,
  input wire logic [ADDR_W-1:0]    res_addr_i,
  input wire logic [PIX_W-1:0]     res_pixel_i,
  input wire logic                 res_last_i,
  input wire logic                 res_err_i
);

  `CRPAG_ASSERT_NEXT(a_cfg_blocks_input, cfg_we_i && (cfg_idx_i <= REG_WINDOW_HEIGHT), !pix_ready_i, "Pixel taken right after a register write.")

  `CRPAG_ASSERT_SAME(a_err_result, res_valid_i && res_err_i, (res_addr_i == '0) && !res_last_i, "Error result carries an address or a last flag.")

  `CRPAG_ASSERT_NEXT(a_res_held, res_valid_i && !res_ready_i, res_valid_i, "Result dropped while stalled.")

  `CRPAG_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_addr_i) && $stable(res_pixel_i) && $stable(res_last_i) && $stable(res_err_i), "Result changed while stalled.")

endmodule

bind crop_rotate_pixel_address_gen_core crpag_checker u_crpag_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_addr_i  (res_o.dest_address),
  .res_pixel_i (res_o.pixel_out),
  .res_last_i  (res_o.last_pixel),
  .res_err_i   (res_o.config_error)
);

`default_nettype wire

// ===== test/crop_rotate_pixel_address_gen_core_test.sv =====
`default_nettype none

module crop_rotate_pixel_address_gen_core_test;
  import crpag_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int unsigned RANDOM_PIXELS = 1950;
  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  crpag_pix_if pix_if ();
  crpag_res_if res_if ();

  crop_rotate_pixel_address_gen_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Register copies and window position as the block should hold them.
  logic [1:0]        turns_q;
  logic [BPP_W-1:0]  bpp_q;
  logic [DIM_W-1:0]  src_w_q;
  logic [CNT_W-1:0]  crop_l_q;
  logic [DIM_W-1:0]  crop_w_q;
  logic [DIM_W-1:0]  win_h_q;
  logic [CNT_W-1:0]  row_idx;
  logic [CNT_W-1:0]  col_idx;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] pix_addr;

  logic [PIX_W-1:0] pixel_q[$];
  res_t             placement_q[$];

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned results_seen  = 0;
  int unsigned windows_done  = 0;
  int unsigned crop_errors   = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  int unsigned setups        = 0;
  logic        pix_fired     = 1'b0;
  logic        steady        = 1'b0;
  logic        hold_req      = 1'b0;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  function automatic int unsigned pixel_bytes();
    if (bpp_q == 0) return 1;
    if (bpp_q > 4) return 4;
    return bpp_q;
  endfunction

  function automatic int unsigned source_span();
    return (src_w_q > MAX_DIMENSION) ? MAX_DIMENSION : src_w_q;
  endfunction

  function automatic logic crop_outside();
    return crop_l_q >= source_span();
  endfunction

  function automatic int unsigned window_w();
    int unsigned w;
    int unsigned room;
    w = clamp_dim(crop_w_q);
    room = crop_outside() ? 1 : source_span() - crop_l_q;
    return (w > room) ? room : w;
  endfunction

  function automatic int unsigned window_h();
    return clamp_dim(win_h_q);
  endfunction

  function automatic int unsigned line_pitch();
    int unsigned span;
    span = (turns_q[0] ? window_h() : window_w()) * pixel_bytes();
    return (span + LINE_ALIGN_BYTES - 1) / LINE_ALIGN_BYTES * LINE_ALIGN_BYTES;
  endfunction

  function automatic logic [ADDR_W-1:0] origin_address();
    longint unsigned w;
    longint unsigned h;
    longint unsigned b;
    longint unsigned l;
    w = window_w();
    h = window_h();
    b = pixel_bytes();
    l = line_pitch();
    case (rot_e'(turns_q))
      ROT_90:  return ADDR_W'((w - 1) * l);
      ROT_180: return ADDR_W'((h - 1) * l + (w - 1) * b);
      ROT_270: return ADDR_W'((h - 1) * b);
      default: return '0;
    endcase
  endfunction

  function automatic void rewind();
    row_idx = '0;
    col_idx = '0;
    row_base = origin_address();
    pix_addr = row_base;
  endfunction

  function automatic res_t place_pixel(logic [PIX_W-1:0] px);
    res_t              r;
    int unsigned       w;
    int unsigned       h;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] l;
    logic [ADDR_W-1:0] across;
    logic [ADDR_W-1:0] down;
    r.pixel_out = px;
    if (crop_outside()) begin
      r.dest_address = '0;
      r.last_pixel = 1'b0;
      r.config_error = 1'b1;
      return r;
    end
    w = window_w();
    h = window_h();
    b = ADDR_W'(pixel_bytes());
    l = ADDR_W'(line_pitch());
    case (rot_e'(turns_q))
      ROT_90: begin
        across = -l;
        down = b;
      end
      ROT_180: begin
        across = -b;
        down = -l;
      end
      ROT_270: begin
        across = l;
        down = -b;
      end
      default: begin
        across = b;
        down = l;
      end
    endcase
    r.dest_address = pix_addr;
    r.last_pixel = (row_idx == h - 1) && (col_idx == w - 1);
    r.config_error = 1'b0;
    if (col_idx + 1 >= w) begin
      col_idx = '0;
      if (row_idx + 1 >= h) begin
        rewind();
      end else begin
        row_idx = row_idx + 1'b1;
        row_base = row_base + down;
        pix_addr = row_base;
      end
    end else begin
      col_idx = col_idx + 1'b1;
      pix_addr = pix_addr + across;
    end
    return r;
  endfunction

  function automatic void compare_field(string field, logic [PIX_W-1:0] want,
                                        logic [PIX_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_QUARTER_TURNS:   turns_q = val[1:0];
      REG_BYTES_PER_PIXEL: bpp_q = val[BPP_W-1:0];
      REG_SOURCE_WIDTH:    src_w_q = val;
      REG_CROP_LEFT:       crop_l_q = val[CNT_W-1:0];
      REG_CROP_WIDTH:      crop_w_q = val;
      REG_WINDOW_HEIGHT:   win_h_q = val;
      default: ;
    endcase
    if (idx <= REG_WINDOW_HEIGHT) rewind();
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] b,
                              logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] cl,
                              logic [CFG_DATA_W-1:0] cw, logic [CFG_DATA_W-1:0] wh);
    write_reg(REG_QUARTER_TURNS, t);
    write_reg(REG_BYTES_PER_PIXEL, b);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_CROP_LEFT, cl);
    write_reg(REG_CROP_WIDTH, cw);
    write_reg(REG_WINDOW_HEIGHT, wh);
    end_writes();
    setups++;
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] t;
    logic [CFG_DATA_W-1:0] b;
    logic [CFG_DATA_W-1:0] sw;
    logic [CFG_DATA_W-1:0] cl;
    logic [CFG_DATA_W-1:0] cw;
    logic [CFG_DATA_W-1:0] wh;
    int unsigned           kind;
    t = CFG_DATA_W'($urandom_range(0, 3));
    kind = $urandom_range(0, 9);
    if (kind == 0) b = '0;
    else if (kind == 1) b = CFG_DATA_W'($urandom_range(5, 7));
    else b = CFG_DATA_W'($urandom_range(1, 4));
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      sw = CFG_DATA_W'($urandom_range(4000, 8191));
      cl = CFG_DATA_W'($urandom_range(0, 4095));
      cw = CFG_DATA_W'($urandom_range(0, 8191));
      wh = CFG_DATA_W'($urandom_range(0, 8191));
    end else if (kind == 1) begin
      sw = CFG_DATA_W'($urandom_range(0, 40));
      cl = CFG_DATA_W'($urandom_range(sw, 4095));
      cw = CFG_DATA_W'($urandom_range(1, 8));
      wh = CFG_DATA_W'($urandom_range(1, 6));
    end else if (kind == 2) begin
      sw = CFG_DATA_W'($urandom_range(1, 12));
      cl = CFG_DATA_W'($urandom_range(0, sw - 1));
      cw = $urandom_range(0, 1) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
      wh = (cw != 0) ? '0 : CFG_DATA_W'($urandom_range(0, 6));
    end else begin
      sw = CFG_DATA_W'($urandom_range(1, 12));
      cl = CFG_DATA_W'($urandom_range(0, sw - 1));
      cw = CFG_DATA_W'($urandom_range(1, 8));
      wh = CFG_DATA_W'($urandom_range(1, 6));
    end
    if ($urandom_range(0, 3) == 0) begin
      t = t | CFG_DATA_W'($urandom_range(0, 2047) << 2);
      b = b | CFG_DATA_W'($urandom_range(0, 1023) << 3);
      cl = cl | 13'h1000;
    end
    apply_config(t, b, sw, cl, cw, wh);
  endtask

  task automatic queue_pixels(int unsigned n);
    logic [PIX_W-1:0] v;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        default: v = $urandom();
      endcase
      pixel_q.push_back(v);
      pixels_queued++;
    end
  endtask

  task automatic wait_drained();
    while (results_seen != pixels_queued) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!pix_if.valid || pix_fired) begin
      if (pixel_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel_value <= pixel_q.pop_front();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    pix_fired = rst_ni && pix_if.valid && pix_if.ready;
    if (pix_fired) begin
      placement_q.push_back(place_pixel(pix_if.pixel_value));
      pixels_taken++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      got.dest_address = res_if.dest_address;
      got.pixel_out = res_if.pixel_out;
      got.last_pixel = res_if.last_pixel;
      got.config_error = res_if.config_error;
      if (placement_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected transaction: expected none, actual address %h pixel %h",
                 $time, got.dest_address, got.pixel_out);
      end else begin
        want = placement_q.pop_front();
        compare_field("dest_address", PIX_W'(want.dest_address), PIX_W'(got.dest_address));
        compare_field("pixel_out", want.pixel_out, got.pixel_out);
        compare_field("last_pixel", PIX_W'(want.last_pixel), PIX_W'(got.last_pixel));
        compare_field("config_error", PIX_W'(want.config_error), PIX_W'(got.config_error));
        if (want.last_pixel) windows_done++;
        if (want.config_error) crop_errors++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pixels_queued - results_seen);
      $display("** crop_rotate_pixel_address_gen_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned           random_pixels;
    int unsigned           phase;
    int unsigned           area;
    int unsigned           n;
    int unsigned           mode;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel_value = '0;
    res_if.ready = 1'b0;
    turns_q = ROT_0;
    bpp_q = 3'd4;
    src_w_q = 13'd1;
    crop_l_q = '0;
    crop_w_q = 13'd1;
    win_h_q = 13'd1;
    rewind();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    pixel_q.push_back('0);
    pixel_q.push_back('1);
    pixels_queued += 2;
    wait_drained();

    // Window narrower than requested, one 2x2 pass per rotation.
    for (int r = 0; r < 4; r++) begin
      apply_config(CFG_DATA_W'(r), 3, 3, 1, 3, 2);
      queue_pixels(4);
      wait_drained();
    end

    apply_config(ROT_90, 2, 5, 5, 3, 2);
    queue_pixels(2);
    wait_drained();

    apply_config(ROT_180, 0, 6, 0, 0, 0);
    queue_pixels(1);
    wait_drained();

    apply_config(ROT_270, 7, 8191, 4095, 8191, 8191);
    queue_pixels(2);
    wait_drained();

    random_pixels = 0;
    phase = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      phase++;
      steady = (phase >= 20 && phase < 30);
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
        random_setup();
      end else if (mode == 7) begin
        idx = CFG_IDX_W'($urandom_range(0, 5));
        val = CFG_DATA_W'($urandom_range(0, 8191));
        write_reg(idx, val);
        end_writes();
      end else if (mode == 8) begin
        val = CFG_DATA_W'($urandom_range(0, 8191));
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, val);
        end_writes();
      end
      area = crop_outside() ? 4 : window_w() * window_h();
      if (area <= 40) n = area * $urandom_range(1, 2) + $urandom_range(0, 3);
      else n = $urandom_range(5, 40);
      if (phase == 8) begin
        n = 60;
        hold_req = 1'b1;
      end
      if (phase == 14) begin
        queue_pixels(n / 2);
        wait_drained();
        queue_pixels(n - n / 2);
      end else begin
        queue_pixels(n);
      end
      random_pixels += n;
      wait_drained();
    end

    repeat (10) @(negedge clk_i);
    if (placement_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, placement_q.size());
    end
    $display("Covered %0d pixels over %0d full setups and %0d random phases.",
             pixels_taken, setups, phase);
    $display("Closed %0d whole windows, saw %0d crop-error results, %0d mismatches.",
             windows_done, crop_errors, fail_count);
    if (fail_count == 0) begin
      $display("** crop_rotate_pixel_address_gen_core: PASSED **");
    end else begin
      $display("** crop_rotate_pixel_address_gen_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
